// ===== src/rdpq_pkg.sv =====
// Package for the random drop packet queue: sizes, status codes, LFSR
// constants, the descriptor and control structs. No dependencies.

package rdpq_pkg;

    localparam int DEPTH = 16;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int ID_W     = 32;
    localparam int IP_W     = 32;
    localparam int STATUS_W = 3;
    localparam int OCC_W    = 4;
    localparam int THR_W    = 4;
    localparam int CHANCE_W = 9;
    localparam int LFSR_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [STATUS_W-1:0] ST_STORED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DEQUEUED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DROPPED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL_KEEP  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL_BELOW = 3'd5;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANCE    = 2'd1;

    localparam logic [THR_W-1:0]    THRESH_RESET = 4'd8;
    localparam logic [CHANCE_W-1:0] CHANCE_RESET = 9'd51;
    localparam logic [LFSR_W-1:0]   LFSR_SEED    = 16'hACE1;
    localparam logic [LFSR_W-1:0]   LFSR_TAPS    = 16'hB400;

    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH - 1);

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [IP_W-1:0] ip;
    } t_entry;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                rd;
        logic                wr;
        logic [PTR_W-1:0]    head;
        logic [PTR_W-1:0]    tail;
        logic [OCC_W-1:0]    occ;
    } t_ctrl;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

endpackage

// ===== src/rdpq_ctrl.sv =====
// Queue control for the random drop packet queue: pointers, fill count,
// LFSR and configuration registers; decides each request. Uses rdpq_pkg.

module rdpq_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  logic                          i_cmd,
    input  logic                          i_cfg_we,
    input  logic [rdpq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rdpq_pkg::CHANCE_W-1:0]  i_cfg_data,
    output rdpq_pkg::t_ctrl               o_dec
);
    import rdpq_pkg::*;

    logic [PTR_W-1:0]    r_head, n_head;
    logic [PTR_W-1:0]    r_tail, n_tail;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [LFSR_W-1:0]   r_lfsr, n_lfsr;
    logic [THR_W-1:0]    r_thresh;
    logic [CHANCE_W-1:0] r_chance;

    logic [LFSR_W-1:0] lfsr_step;
    logic              full;
    logic              over;
    logic              drop;

    always_comb begin
        lfsr_step = {1'b0, r_lfsr[LFSR_W-1:1]} ^ (r_lfsr[0] ? LFSR_TAPS : '0);
        full = r_count >= CNT_W'(DEPTH - 1);
        over = 32'(r_count) >= 32'(r_thresh);
        drop = {1'b0, lfsr_step[7:0]} < r_chance;

        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_lfsr  = r_lfsr;
        o_dec.rd = 1'b0;
        o_dec.wr = 1'b0;

        if (i_cmd == CMD_DEQ) begin
            if (r_count == '0) begin
                o_dec.status = ST_EMPTY;
            end else begin
                o_dec.status = ST_DEQUEUED;
                o_dec.rd = 1'b1;
                n_head  = ring_next(r_head);
                n_count = r_count - CNT_W'(1);
            end
        end else if (full) begin
            if (over) begin
                n_lfsr = lfsr_step;
                if (drop) begin
                    o_dec.status = ST_DROPPED;
                    o_dec.rd = 1'b1;
                    n_head  = ring_next(r_head);
                    n_count = r_count - CNT_W'(1);
                end else begin
                    o_dec.status = ST_FULL_KEEP;
                end
            end else begin
                o_dec.status = ST_FULL_BELOW;
            end
        end else begin
            o_dec.status = ST_STORED;
            o_dec.wr = 1'b1;
            n_tail  = ring_next(r_tail);
            n_count = r_count + CNT_W'(1);
        end

        o_dec.head = r_head;
        o_dec.tail = r_tail;
        o_dec.occ  = OCC_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_lfsr  <= LFSR_SEED;
        end else if (i_take) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_lfsr  <= n_lfsr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
            r_chance <= CHANCE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD: r_thresh <= i_cfg_data[THR_W-1:0];
                CFG_CHANCE:    r_chance <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== src/random_drop_packet_queue.sv =====
// Random drop packet queue, top level: descriptor memory, result pipeline
// and output register. Uses rdpq_pkg and rdpq_ctrl.
//
// Ring queue of packet descriptors (id, source address) holding up to
// DEPTH-1 entries. Each request (enqueue or dequeue) yields one result with
// a status, the head descriptor when one is popped or dropped, and the fill
// level after the request. A request is taken every cycle while results
// drain; its result is registered first in the pending stage, beside the
// registered read of the descriptor memory, and then in the output register.
// An enqueue on a full queue loses the packet and, at or above the fill
// threshold, drops the head with probability drop_chance/256 from a 16-bit
// LFSR. Configuration writes are always accepted and apply to requests taken after the write.

module random_drop_packet_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_cmd,
    input  logic [rdpq_pkg::ID_W-1:0]       i_packet_id,
    input  logic [rdpq_pkg::IP_W-1:0]       i_src_ip,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [rdpq_pkg::STATUS_W-1:0]   o_status,
    output logic [rdpq_pkg::ID_W-1:0]       o_out_packet_id,
    output logic [rdpq_pkg::IP_W-1:0]       o_out_src_ip,
    output logic [rdpq_pkg::OCC_W-1:0]      o_occupancy,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rdpq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rdpq_pkg::CHANCE_W-1:0]   i_cfg_data
);
    import rdpq_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd;
    t_ctrl  dec;

    logic                r_pend_v;
    logic [STATUS_W-1:0] r_pend_status;
    logic                r_pend_rd;
    logic [OCC_W-1:0]    r_pend_occ;
    logic                r_out_v;

    logic take;
    logic move;

    assign o_cfg_ready = 1'b1;
    assign move        = r_pend_v && (!r_out_v || i_out_ready);
    assign o_in_ready  = !r_pend_v || move;
    assign take        = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_v;

    rdpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_cmd       (i_cmd),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_dec       (dec)
    );

    // descriptor memory: write at tail, registered read at head
    always_ff @(posedge i_clk) begin
        if (take && dec.wr) begin
            r_mem[dec.tail] <= '{id: i_packet_id, ip: i_src_ip};
        end
        if (take) begin
            r_rd <= r_mem[dec.head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
        end else if (take) begin
            r_pend_v <= 1'b1;
        end else if (move) begin
            r_pend_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_pend_status <= dec.status;
            r_pend_rd     <= dec.rd;
            r_pend_occ    <= dec.occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (move) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            o_status        <= r_pend_status;
            o_out_packet_id <= r_pend_rd ? r_rd.id : '0;
            o_out_src_ip    <= r_pend_rd ? r_rd.ip : '0;
            o_occupancy     <= r_pend_occ;
        end
    end

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_EMPTY |-> o_occupancy == '0)
        else $error("empty result with nonzero occupancy");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL_KEEP || o_status == ST_FULL_BELOW)
        |-> o_occupancy == OCC_FULL)
        else $error("full result without full occupancy");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v && r_out_v && !i_out_ready |-> !o_in_ready)
        else $error("request taken while result path stalled");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v && !move |=> r_pend_v && $stable(r_pend_status))
        else $error("pending result lost");

endmodule
